// ----- hw/rtl/priority_ready_blocked_queues_macros.svh -----
// Assertion macros for the queue manager RTL.
`ifndef PRIORITY_READY_BLOCKED_QUEUES_MACROS_SVH
`define PRIORITY_READY_BLOCKED_QUEUES_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define PRBQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("prbq assertion failed");
// Check that a condition never holds outside reset.
`define PRBQ_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("prbq forbidden condition seen");
`else
`define PRBQ_ASSERT(lbl, clk, rstn, prop)
`define PRBQ_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- hw/rtl/prbq_pkg.sv -----
`default_nettype none

package prbq_pkg;

	// Table sizes
	localparam int PROCS       = 16;
	localparam int LEVELS      = 5;
	localparam int WAIT_QUEUES = 1;

	// Derived widths: slot index, pointer with a null code, queue indexes
	localparam int SLOT_W = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int PTR_W  = $clog2(PROCS + 1);
	localparam int LVL_IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int WQ_IW  = (WAIT_QUEUES > 1) ? $clog2(WAIT_QUEUES) : 1;

	// Fixed field widths of the stream words
	localparam int ACT_W  = 2;
	localparam int PID_W  = 4;
	localparam int PRI_W  = 3;
	localparam int WQ_W   = 1;
	localparam int IN_W   = 16;
	localparam int OUT_W  = 8;

	// Null pointer
	localparam logic [PTR_W-1:0] NIL = PTR_W'(PROCS);

	typedef enum logic [1:0] {
		ACT_ENQ_READY   = 2'd0,
		ACT_ENQ_BLOCKED = 2'd1,
		ACT_REMOVE      = 2'd2,
		ACT_UNBLOCK     = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_READY   = 2'd1,
		ST_BLOCKED = 2'd2
	} slot_st_t;

	// One write into the link table
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [PTR_W-1:0]  data;
	} link_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/prbq_links.sv -----
`default_nettype none

// Next-link table over the process slots: one read port, one write port.
module prbq_links (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  [prbq_pkg::SLOT_W-1:0]   rd_addr,
	output logic [prbq_pkg::PTR_W-1:0]    rd_data,
	input  prbq_pkg::link_wr_t            wr
);
	import prbq_pkg::*;

	logic [PTR_W-1:0] link_q [PROCS];

	// Update one link per cycle; reset points every slot at null
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PROCS; i++) begin
				link_q[i] <= NIL;
			end
		end else if (wr.we) begin
			link_q[wr.addr] <= wr.data;
		end
	end

	// Read the link of the slot under the walk pointer
	assign rd_data = link_q[rd_addr];

endmodule

`default_nettype wire

// ----- hw/rtl/priority_ready_blocked_queues.sv -----
`default_nettype none
`include "priority_ready_blocked_queues_macros.svh"

// Channel  Dir  Handshake            Word layout (low bit up)
// s        in   s_tvalid / s_tready  action[1:0] slot_id[5:2] priority_req[8:6] wait_queue[9]
// m        out  m_tvalid / m_tready  proc_state[1:0] ignored[2] head_id[6:3] head_valid[7]
//
// One request at a time: accept, decide, a list walk through the single read port of the
// link table, two link writes at most per unlink and per append, then the result. A move
// found at the end of a full list is the worst case; an enqueue to ready skips the walk
// and the unlink. The single link table write port is why these writes take separate
// steps. Reset empties all queues and marks every slot not queued, no clearing pass.
// A result waiting on m_tready stalls the next request only at its result step.
module priority_ready_blocked_queues (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [prbq_pkg::IN_W-1:0]     s_tdata,  // action, slot_id, priority_req, wait_queue
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [prbq_pkg::OUT_W-1:0]    m_tdata   // proc_state, ignored, head_id, head_valid
);
	import prbq_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_WALK   = 8'b0000_0100,
		S_UNL_A  = 8'b0000_1000,
		S_UNL_B  = 8'b0001_0000,
		S_APP_A  = 8'b0010_0000,
		S_APP_B  = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t            state_q;
	act_t              act_q;
	logic [PID_W-1:0]  pid_q;
	logic [PRI_W-1:0]  lvl_q;
	logic [WQ_W-1:0]   wq_q;
	logic              qblk_q;
	logic              ign_q;
	logic [PTR_W-1:0]  cur_q;
	logic [PTR_W-1:0]  prev_q;
	logic [PTR_W-1:0]  nx_q;
	logic [PTR_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  rhead_q [LEVELS];
	logic [PTR_W-1:0]  rtail_q [LEVELS];
	logic [PTR_W-1:0]  bhead_q [WAIT_QUEUES];
	logic [PTR_W-1:0]  btail_q [WAIT_QUEUES];
	slot_st_t          status_q [PROCS];
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic              pid_ok;
	logic              lvl_ok;
	logic              wq_ok;
	logic [SLOT_W-1:0] slot;
	logic [PTR_W-1:0]  pid_ptr;
	logic [LVL_IW-1:0] lidx;
	logic [WQ_IW-1:0]  widx;
	logic [PTR_W-1:0]  q_head;
	logic [PTR_W-1:0]  q_tail;
	logic              cur_null;
	logic [PTR_W-1:0]  link_rd;
	link_wr_t          link_wr;
	slot_st_t          st_now;
	logic [PTR_W-1:0]  res_head;
	logic              res_hv;
	logic [1:0]        res_st;

	// Decode request fields
	assign pid_ok   = int'(pid_q) < PROCS;
	assign lvl_ok   = int'(lvl_q) < LEVELS;
	assign wq_ok    = int'(wq_q) < WAIT_QUEUES;
	assign slot     = SLOT_W'(pid_q);
	assign pid_ptr  = PTR_W'(pid_q);
	assign lidx     = LVL_IW'(lvl_q);
	assign widx     = WQ_IW'(wq_q);
	assign st_now   = pid_ok ? status_q[slot] : ST_IDLE;
	assign q_head   = qblk_q ? bhead_q[widx] : rhead_q[lidx];
	assign q_tail   = qblk_q ? btail_q[widx] : rtail_q[lidx];
	assign cur_null = cur_q >= NIL;

	// Head of the affected queue and slot state for the result word
	always_comb begin
		res_head = NIL;
		if (act_q == ACT_ENQ_BLOCKED) begin
			if (wq_ok) res_head = bhead_q[widx];
		end else if (lvl_ok) begin
			res_head = rhead_q[lidx];
		end
		res_hv = res_head < NIL;
		res_st = pid_ok ? status_q[slot] : ST_IDLE;
	end

	// Select the link write of the current step
	always_comb begin
		link_wr = '0;
		unique case (state_q)
			S_UNL_A: begin
				if (prev_q < NIL) begin
					link_wr.we   = 1'b1;
					link_wr.addr = SLOT_W'(prev_q);
					link_wr.data = nx_q;
				end
			end
			S_UNL_B, S_APP_A: begin
				link_wr.we   = 1'b1;
				link_wr.addr = slot;
				link_wr.data = NIL;
			end
			S_APP_B: begin
				if (q_head < NIL && q_tail < NIL) begin
					link_wr.we   = 1'b1;
					link_wr.addr = SLOT_W'(q_tail);
					link_wr.data = pid_ptr;
				end
			end
			default: link_wr = '0;
		endcase
	end

	prbq_links u_links (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (SLOT_W'(cur_q)),
		.rd_data (link_rd),
		.wr      (link_wr)
	);

	// Capture request fields; payload needs no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			act_q <= act_t'(s_tdata[ACT_W-1:0]);
			pid_q <= s_tdata[ACT_W +: PID_W];
			lvl_q <= s_tdata[ACT_W+PID_W +: PRI_W];
			wq_q  <= s_tdata[ACT_W+PID_W+PRI_W +: WQ_W];
		end
	end

	// Sequence one request over the queues
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			qblk_q     <= 1'b0;
			ign_q      <= 1'b1;
			cur_q      <= NIL;
			prev_q     <= NIL;
			nx_q       <= NIL;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				rhead_q[i] <= NIL;
				rtail_q[i] <= NIL;
			end
			for (int i = 0; i < WAIT_QUEUES; i++) begin
				bhead_q[i] <= NIL;
				btail_q[i] <= NIL;
			end
			for (int i = 0; i < PROCS; i++) begin
				status_q[i] <= ST_IDLE;
			end
		end else begin
			// drop a taken result word unless the next one loads now
			if (m_tvalid_q && m_tready && state_q != S_FINISH) m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					ign_q  <= 1'b1;
					prev_q <= NIL;
					cnt_q  <= '0;
					if (!(pid_ok && lvl_ok)) begin
						state_q <= S_FINISH;
					end else begin
						unique case (act_q)
							ACT_ENQ_READY: begin
								if (st_now == ST_IDLE) begin
									qblk_q  <= 1'b0;
									state_q <= S_APP_A;
								end else begin
									state_q <= S_FINISH;
								end
							end
							ACT_ENQ_BLOCKED: begin
								if (wq_ok && st_now == ST_READY) begin
									qblk_q  <= 1'b0;
									cur_q   <= rhead_q[lidx];
									state_q <= S_WALK;
								end else if (wq_ok && st_now == ST_IDLE) begin
									qblk_q  <= 1'b1;
									state_q <= S_APP_A;
								end else begin
									state_q <= S_FINISH;
								end
							end
							ACT_REMOVE: begin
								if (st_now == ST_READY) begin
									qblk_q  <= 1'b0;
									cur_q   <= rhead_q[lidx];
									state_q <= S_WALK;
								end else begin
									state_q <= S_FINISH;
								end
							end
							ACT_UNBLOCK: begin
								if (wq_ok && st_now == ST_BLOCKED) begin
									qblk_q  <= 1'b1;
									cur_q   <= bhead_q[widx];
									state_q <= S_WALK;
								end else begin
									state_q <= S_FINISH;
								end
							end
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_WALK: begin
					// advance one slot per cycle until found, end of list or bound
					if (cur_null || cnt_q == NIL) begin
						state_q <= S_FINISH;
					end else if (cur_q == pid_ptr) begin
						nx_q    <= link_rd;
						state_q <= S_UNL_A;
					end else begin
						prev_q <= cur_q;
						cur_q  <= link_rd;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				S_UNL_A: begin
					// bypass the slot through its predecessor's link or the head, fix the tail
					if (prev_q >= NIL) begin
						if (qblk_q) bhead_q[widx] <= nx_q;
						else        rhead_q[lidx] <= nx_q;
					end
					if (q_tail == pid_ptr) begin
						if (qblk_q) btail_q[widx] <= prev_q;
						else        rtail_q[lidx] <= prev_q;
					end
					state_q <= S_UNL_B;
				end
				S_UNL_B: begin
					case (act_q)
						ACT_REMOVE: begin
							status_q[slot] <= ST_IDLE;
							ign_q          <= 1'b0;
							state_q        <= S_FINISH;
						end
						ACT_ENQ_BLOCKED: begin
							qblk_q  <= 1'b1;
							state_q <= S_APP_A;
						end
						ACT_UNBLOCK: begin
							qblk_q  <= 1'b0;
							state_q <= S_APP_A;
						end
						default: state_q <= S_FINISH;
					endcase
				end
				S_APP_A: begin
					state_q <= S_APP_B;
				end
				S_APP_B: begin
					// link the slot at the tail, or start an empty queue
					if (q_head >= NIL || q_tail >= NIL) begin
						if (qblk_q) bhead_q[widx] <= pid_ptr;
						else        rhead_q[lidx] <= pid_ptr;
					end
					if (qblk_q) btail_q[widx] <= pid_ptr;
					else        rtail_q[lidx] <= pid_ptr;
					status_q[slot] <= (act_q == ACT_ENQ_BLOCKED) ? ST_BLOCKED : ST_READY;
					ign_q   <= 1'b0;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {res_hv, res_hv ? 4'(res_head) : 4'd0, ign_q, res_st};
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PRBQ_ASSERT(a_walk_bound, clk, arst_n, cnt_q <= NIL)
	`PRBQ_ASSERT(a_result_from_finish, clk, arst_n, $rose(m_tvalid) |-> $past(state_q == S_FINISH))
	`PRBQ_ASSERT_NEVER(a_blocked_ends_agree, clk, arst_n, (bhead_q[0] == NIL) != (btail_q[0] == NIL))
	`PRBQ_ASSERT(a_accept_to_decide, clk, arst_n, (s_tvalid && s_tready) |=> state_q == S_DECIDE)

endmodule

`default_nettype wire
